### design/clcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcd_pkg: shared types and constants for the character LCD byte former
// Command and register codes, sequencer states and LCD command constants.
// ----------------------------------------------------------------------------
package clcd_pkg;

  // request commands
  localparam logic [2:0] CMD_PUT_CHAR  = 3'd0;
  localparam logic [2:0] CMD_SET_POS   = 3'd1;
  localparam logic [2:0] CMD_CURSOR    = 3'd2;
  localparam logic [2:0] CMD_SCREEN    = 3'd3;
  localparam logic [2:0] CMD_BACKLIGHT = 3'd4;

  // configuration register indexes
  localparam logic [2:0] CFG_PANEL_KIND    = 3'd0;
  localparam logic [2:0] CFG_NEWLINE_PADS  = 3'd1;
  localparam logic [2:0] CFG_BACKLIGHT_BIT = 3'd2;
  localparam logic [2:0] CFG_ENABLE_BIT    = 3'd3;
  localparam logic [2:0] CFG_RS_BIT        = 3'd4;

  // special characters
  localparam logic [7:0] CHAR_HOME    = 8'h00;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;

  // LCD command bits
  localparam logic [7:0] LCD_SET_DDRAM  = 8'h80;
  localparam logic [6:0] DDRAM_ROW1     = 7'h40;
  localparam logic [7:0] DC_COMMAND     = 8'h08;
  localparam logic [7:0] DC_SCREEN_ON   = 8'h04;
  localparam logic [7:0] DC_CURSOR_ON   = 8'h02;
  localparam logic [7:0] DC_BLINK_ON    = 8'h01;
  localparam logic [7:0] DC_RESET       = 8'h08;

  // cursor settings
  localparam logic [1:0] SETTING_OFF   = 2'd0;
  localparam logic [1:0] SETTING_BLINK = 2'd2;

  // panel geometry
  localparam logic [4:0] COLS_NARROW = 5'd16;
  localparam logic [4:0] COLS_WIDE   = 5'd20;
  localparam logic [2:0] ROWS_NARROW = 3'd2;
  localparam logic [2:0] ROWS_WIDE   = 3'd4;

  // result classes
  localparam logic [2:0] COUNT_LCD       = 3'd4;
  localparam logic [2:0] COUNT_BACKLIGHT = 3'd1;
  localparam logic [1:0] WAIT_NONE       = 2'd0;
  localparam logic [1:0] WAIT_COMMAND    = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_PAD,
    S_POS
  } state_t;

  // operand of the shared transfer former
  typedef struct packed {
    logic [7:0] value;
    logic       is_data;
  } xfer_req_t;

endpackage

### design/clcd_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcd_ifs: channel interfaces of the character LCD byte former
// Request channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface clcd_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [7:0] char_code;
  logic [7:0] column_request;
  logic [7:0] row_request;
  logic [1:0] setting;

  modport source (output valid, cmd, char_code, column_request, row_request, setting,
                  input ready);
  modport sink   (input valid, cmd, char_code, column_request, row_request, setting,
                  output ready);
endinterface

interface clcd_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte0;
  logic [7:0] byte1;
  logic [7:0] byte2;
  logic [7:0] byte3;
  logic [2:0] byte_count;
  logic [1:0] final_wait;
  logic       last;

  modport source (output valid, byte0, byte1, byte2, byte3, byte_count, final_wait, last,
                  input ready);
  modport sink   (input valid, byte0, byte1, byte2, byte3, byte_count, final_wait, last,
                  output ready);
endinterface

interface clcd_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [3:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### design/char_lcd_text_to_expander_bytes.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_text_to_expander_bytes: character LCD text to I2C expander bytes
// Tracks cursor, display control and backlight; forms 4-bit bus transfers.
// ----------------------------------------------------------------------------
// Sequence: a request is held and decoded; a plain character, mode or backlight
//   request loads its result from decode, while set position, home and newline
//   load theirs from the position state, a padded newline after its pad spaces.
// Flow: no new request is taken until the sequencer is back in idle; one transfer
//   former is shared by the sequencer and yields at most one result per cycle.
// Reset: synchronous; registers to their defaults, cursor home, backlight off.
// ----------------------------------------------------------------------------
module char_lcd_text_to_expander_bytes (
  input logic       clk,
  input logic       rst,
  clcd_req_if.sink  req,
  clcd_res_if.source res,
  clcd_cfg_if.sink  cfg
);
  import clcd_pkg::*;

  // sequencer
  state_t state, state_next;

  // held request
  logic [2:0] cmd_q;
  logic [7:0] char_q;
  logic [7:0] colreq_q;
  logic [7:0] rowreq_q;
  logic [1:0] setting_q;

  // configuration
  logic       panel_kind;
  logic       newline_pads_line;
  logic [3:0] backlight_bit;
  logic [3:0] enable_bit;
  logic [3:0] register_select_bit;

  // display state
  logic [4:0] cursor_column;
  logic [1:0] cursor_row;
  logic [7:0] display_control;
  logic       backlight_on;

  // position target, latched on decode
  logic [4:0] tgt_col, tgt_col_next;
  logic [1:0] tgt_row, tgt_row_next;

  // result register
  logic       res_valid;
  logic [7:0] res_b0, res_b1, res_b2, res_b3;
  logic [2:0] res_count;
  logic [1:0] res_wait;
  logic       res_last;

  // geometry and shared compare
  logic [4:0] cols;
  logic [2:0] rows;
  logic       out_free;
  logic       col_fits;
  logic [4:0] col_plus;
  logic       is_newline;
  logic       is_home;
  logic [2:0] row_plus;

  // control from the sequencer
  logic       emit;
  logic       emit_last;
  logic       bl_mode;
  logic       col_inc;
  logic       dc_we;
  logic       bl_we;
  logic       pos_we;
  logic [7:0] dc_new;
  xfer_req_t  xfer;
  logic [6:0] ddram_addr;

  // shared transfer former
  logic       bl_level;
  logic [7:0] en8, bl8, rs8;
  logic [7:0] hi_n, lo_n;
  logic [7:0] fb0, fb1, fb2, fb3;

  function automatic logic [7:0] with_bl(input logic [7:0] b, input logic on,
                                         input logic [7:0] mask);
    return on ? (b | mask) : (b & ~mask);
  endfunction

  assign cols       = panel_kind ? COLS_WIDE : COLS_NARROW;
  assign rows       = panel_kind ? ROWS_WIDE : ROWS_NARROW;
  assign out_free   = !res_valid || res.ready;
  assign col_fits   = cursor_column < cols;
  assign col_plus   = cursor_column + 5'd1;
  assign row_plus   = {1'b0, cursor_row} + 3'd1;
  assign is_newline = (char_q == CHAR_NEWLINE);
  assign is_home    = (char_q == CHAR_HOME);

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  // configuration writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      panel_kind          <= 1'b0;
      newline_pads_line   <= 1'b0;
      backlight_bit       <= 4'h8;
      enable_bit          <= 4'h4;
      register_select_bit <= 4'h1;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_PANEL_KIND:    panel_kind          <= cfg.data[0];
        CFG_NEWLINE_PADS:  newline_pads_line   <= cfg.data[0];
        CFG_BACKLIGHT_BIT: backlight_bit       <= cfg.data;
        CFG_ENABLE_BIT:    enable_bit          <= cfg.data;
        CFG_RS_BIT:        register_select_bit <= cfg.data;
        default: ;
      endcase
    end
  end

  // hold the request while the sequencer works on it
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      cmd_q     <= req.cmd;
      char_q    <= req.char_code;
      colreq_q  <= req.column_request;
      rowreq_q  <= req.row_request;
      setting_q <= req.setting;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req.valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        case (cmd_q)
          CMD_PUT_CHAR: begin
            if (is_newline) begin
              state_next = (newline_pads_line && col_fits) ? S_PAD : S_POS;
            end else if (is_home) begin
              state_next = S_POS;
            end else if (!col_fits || out_free) begin
              state_next = S_IDLE;
            end
          end
          CMD_SET_POS: state_next = S_POS;
          CMD_CURSOR, CMD_SCREEN, CMD_BACKLIGHT: begin
            if (out_free) state_next = S_IDLE;
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_PAD: begin
        if (out_free && !(col_plus < cols)) state_next = S_POS;
      end
      S_POS: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs: operand of the former, emit strobe, state updates
  always_comb begin
    emit         = 1'b0;
    emit_last    = 1'b1;
    bl_mode      = 1'b0;
    col_inc      = 1'b0;
    dc_we        = 1'b0;
    bl_we        = 1'b0;
    pos_we       = 1'b0;
    dc_new       = display_control | DC_COMMAND;
    xfer.value   = char_q;
    xfer.is_data = 1'b1;
    tgt_col_next = tgt_col;
    tgt_row_next = tgt_row;
    case (state)
      S_DECODE: begin
        case (cmd_q)
          CMD_PUT_CHAR: begin
            if (is_newline) begin
              tgt_col_next = '0;
              tgt_row_next = (row_plus < rows) ? row_plus[1:0] : 2'd0;
            end else if (is_home) begin
              tgt_col_next = '0;
              tgt_row_next = '0;
            end else if (col_fits) begin
              emit    = out_free;
              col_inc = out_free;
            end
          end
          CMD_SET_POS: begin
            // clamp to the panel's last column and row
            tgt_col_next = (colreq_q >= {3'b000, cols}) ? cols - 5'd1 : colreq_q[4:0];
            tgt_row_next = (rowreq_q >= {5'b00000, rows}) ? 2'(rows - 3'd1)
                                                          : rowreq_q[1:0];
          end
          CMD_CURSOR: begin
            dc_new = display_control | DC_COMMAND;
            dc_new = (setting_q != SETTING_OFF) ? (dc_new | DC_CURSOR_ON)
                                                : (dc_new & ~DC_CURSOR_ON);
            dc_new = (setting_q == SETTING_BLINK) ? (dc_new | DC_BLINK_ON)
                                                  : (dc_new & ~DC_BLINK_ON);
            xfer.value   = dc_new;
            xfer.is_data = 1'b0;
            emit         = out_free;
            dc_we        = out_free;
          end
          CMD_SCREEN: begin
            dc_new = display_control | DC_COMMAND;
            dc_new = (setting_q != SETTING_OFF) ? (dc_new | DC_SCREEN_ON)
                                                : (dc_new & ~DC_SCREEN_ON);
            xfer.value   = dc_new;
            xfer.is_data = 1'b0;
            emit         = out_free;
            dc_we        = out_free;
          end
          CMD_BACKLIGHT: begin
            bl_mode = 1'b1;
            emit    = out_free;
            bl_we   = out_free;
          end
          default: ;
        endcase
      end
      S_PAD: begin
        xfer.value   = CHAR_SPACE;
        xfer.is_data = 1'b1;
        emit         = out_free;
        emit_last    = 1'b0;
        col_inc      = out_free;
      end
      S_POS: begin
        xfer.value   = LCD_SET_DDRAM | {1'b0, ddram_addr};
        xfer.is_data = 1'b0;
        emit         = out_free;
        pos_we       = out_free;
      end
      default: ;
    endcase
  end

  // row base of the DDRAM map plus column
  always_comb begin
    case (tgt_row)
      2'd0:    ddram_addr = {2'b00, tgt_col};
      2'd1:    ddram_addr = DDRAM_ROW1 + {2'b00, tgt_col};
      2'd2:    ddram_addr = {2'b00, cols} + {2'b00, tgt_col};
      default: ddram_addr = DDRAM_ROW1 + {2'b00, cols} + {2'b00, tgt_col};
    endcase
  end

  // shared transfer former: nibble split, RS, enable strobe, backlight line
  assign bl_level = bl_mode ? (setting_q != SETTING_OFF) : backlight_on;
  assign en8  = {4'h0, enable_bit};
  assign bl8  = {4'h0, backlight_bit};
  assign rs8  = xfer.is_data ? {4'h0, register_select_bit} : 8'h00;
  assign hi_n = {xfer.value[7:4], 4'h0} | rs8;
  assign lo_n = {xfer.value[3:0], 4'h0} | rs8;
  assign fb0  = with_bl(hi_n | en8, bl_level, bl8);
  assign fb1  = with_bl((hi_n | en8) & ~en8, bl_level, bl8);
  assign fb2  = with_bl(lo_n | en8, bl_level, bl8);
  assign fb3  = with_bl((lo_n | en8) & ~en8, bl_level, bl8);

  // sequencer and display state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      cursor_column   <= '0;
      cursor_row      <= '0;
      display_control <= DC_RESET;
      backlight_on    <= 1'b0;
    end else begin
      state <= state_next;
      if (col_inc) cursor_column <= col_plus;
      if (pos_we) begin
        cursor_column <= tgt_col;
        cursor_row    <= tgt_row;
      end
      if (dc_we) display_control <= dc_new;
      if (bl_we) backlight_on <= (setting_q != SETTING_OFF);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DECODE) begin
      tgt_col <= tgt_col_next;
      tgt_row <= tgt_row_next;
    end
  end

  // result register: load on emit, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_last <= emit_last;
      if (bl_mode) begin
        res_b0    <= with_bl(8'h00, bl_level, bl8);
        res_b1    <= 8'h00;
        res_b2    <= 8'h00;
        res_b3    <= 8'h00;
        res_count <= COUNT_BACKLIGHT;
        res_wait  <= WAIT_NONE;
      end else begin
        res_b0    <= fb0;
        res_b1    <= fb1;
        res_b2    <= fb2;
        res_b3    <= fb3;
        res_count <= COUNT_LCD;
        res_wait  <= WAIT_COMMAND;
      end
    end
  end

  assign res.valid      = res_valid;
  assign res.byte0      = res_b0;
  assign res.byte1      = res_b1;
  assign res.byte2      = res_b2;
  assign res.byte3      = res_b3;
  assign res.byte_count = res_count;
  assign res.final_wait = res_wait;
  assign res.last       = res_last;

  // the cursor never runs past the widest panel
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    cursor_column <= COLS_WIDE)
    else $error("cursor column out of range");

  // an accepted request is decoded in the next cycle
  a_decode: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state == S_DECODE))
    else $error("request not decoded");

  // only padding spaces are non-final, and they are full LCD transfers
  a_nonfinal: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.last) |-> (res.byte_count == COUNT_LCD))
    else $error("non-final result is not an LCD transfer");

  // padding only runs while the cursor is still on the line
  a_pad: assert property (@(posedge clk) disable iff (rst)
    (state == S_PAD) |-> col_fits)
    else $error("padding past the last column");

endmodule

### bench/char_lcd_text_to_expander_bytes_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_text_to_expander_bytes_test: self-checking bench for the LCD byte former
// Drives text and control requests through several register settings and idle
// patterns. A scoreboard predicts each expander transfer and checks the results
// in order.
// ----------------------------------------------------------------------------
import clcd_pkg::*;

typedef struct packed {
  logic [2:0] cmd;
  logic [7:0] char_code;
  logic [7:0] column_request;
  logic [7:0] row_request;
  logic [1:0] setting;
} lcd_request_t;

typedef struct packed {
  logic [7:0] byte0;
  logic [7:0] byte1;
  logic [7:0] byte2;
  logic [7:0] byte3;
  logic [2:0] byte_count;
  logic [1:0] final_wait;
  logic       last;
} lcd_transfer_t;

// Tracks the display state of the block and holds the transfers still owed.
class expander_byte_checker;
  logic       wide_panel;
  logic       pad_newline;
  logic [7:0] lamp_mask;
  logic [7:0] enable_mask;
  logic [7:0] select_mask;

  logic [4:0] cur_col;
  logic [1:0] cur_row;
  logic [7:0] disp_ctl;
  logic       lamp_on;

  lcd_transfer_t pending_transfers[$];
  lcd_transfer_t new_transfers[$];
  int errors;

  function new();
    wide_panel  = 1'b0;
    pad_newline = 1'b0;
    lamp_mask   = 8'h08;
    enable_mask = 8'h04;
    select_mask = 8'h01;
    cur_col     = '0;
    cur_row     = '0;
    disp_ctl    = DC_RESET;
    lamp_on     = 1'b0;
    errors      = 0;
  endfunction

  function void write_register(logic [2:0] index, logic [3:0] value);
    case (index)
      CFG_PANEL_KIND:    wide_panel  = value[0];
      CFG_NEWLINE_PADS:  pad_newline = value[0];
      CFG_BACKLIGHT_BIT: lamp_mask   = {4'h0, value};
      CFG_ENABLE_BIT:    enable_mask = {4'h0, value};
      CFG_RS_BIT:        select_mask = {4'h0, value};
      default: ;
    endcase
  endfunction

  function int column_count();
    return wide_panel ? COLS_WIDE : COLS_NARROW;
  endfunction

  function int row_count();
    return wide_panel ? ROWS_WIDE : ROWS_NARROW;
  endfunction

  function logic [7:0] with_lamp(logic [7:0] b);
    return lamp_on ? (b | lamp_mask) : (b & ~lamp_mask);
  endfunction

  // One 4-bit bus transfer: high nibble then low nibble, each strobed by E.
  function void push_transfer(logic [7:0] value, logic is_data);
    logic [7:0] hi;
    logic [7:0] lo;
    lcd_transfer_t t;
    hi = value & 8'hF0;
    lo = {value[3:0], 4'h0};
    if (is_data) begin
      hi = hi | select_mask;
      lo = lo | select_mask;
    end
    hi = hi | enable_mask;
    lo = lo | enable_mask;
    t.byte0      = with_lamp(hi);
    t.byte1      = with_lamp(hi & ~enable_mask);
    t.byte2      = with_lamp(lo);
    t.byte3      = with_lamp(lo & ~enable_mask);
    t.byte_count = COUNT_LCD;
    t.final_wait = WAIT_COMMAND;
    t.last       = 1'b0;
    new_transfers.push_back(t);
  endfunction

  function void move_cursor(int col, int row);
    int addr;
    if (row >= row_count()) row = row_count() - 1;
    if (col >= column_count()) col = column_count() - 1;
    case (row)
      0:       addr = 0;
      1:       addr = DDRAM_ROW1;
      2:       addr = column_count();
      default: addr = DDRAM_ROW1 + column_count();
    endcase
    addr = addr + col;
    cur_col = col[4:0];
    cur_row = row[1:0];
    push_transfer(LCD_SET_DDRAM | addr[7:0], 1'b0);
  endfunction

  function void put_plain(logic [7:0] c);
    if (cur_col < column_count()) begin
      push_transfer(c, 1'b1);
      cur_col = cur_col + 5'd1;
    end
  endfunction

  function void new_line();
    int next_row;
    if (pad_newline) begin
      while (cur_col < column_count()) put_plain(CHAR_SPACE);
    end
    next_row = cur_row + 1;
    if (next_row < row_count()) move_cursor(0, next_row);
    else move_cursor(0, 0);
  endfunction

  // Note an accepted request; returns the number of transfers it owes.
  function int note_request(lcd_request_t r);
    lcd_transfer_t t;
    new_transfers.delete();
    case (r.cmd)
      CMD_PUT_CHAR: begin
        if (r.char_code == CHAR_NEWLINE) new_line();
        else if (r.char_code == CHAR_HOME) move_cursor(0, 0);
        else put_plain(r.char_code);
      end
      CMD_SET_POS: move_cursor(r.column_request, r.row_request);
      CMD_CURSOR: begin
        disp_ctl = disp_ctl | DC_COMMAND;
        if (r.setting != SETTING_OFF) disp_ctl = disp_ctl | DC_CURSOR_ON;
        else disp_ctl = disp_ctl & ~DC_CURSOR_ON;
        if (r.setting == SETTING_BLINK) disp_ctl = disp_ctl | DC_BLINK_ON;
        else disp_ctl = disp_ctl & ~DC_BLINK_ON;
        push_transfer(disp_ctl, 1'b0);
      end
      CMD_SCREEN: begin
        disp_ctl = disp_ctl | DC_COMMAND;
        if (r.setting != SETTING_OFF) disp_ctl = disp_ctl | DC_SCREEN_ON;
        else disp_ctl = disp_ctl & ~DC_SCREEN_ON;
        push_transfer(disp_ctl, 1'b0);
      end
      CMD_BACKLIGHT: begin
        lamp_on      = (r.setting != SETTING_OFF);
        t            = '0;
        t.byte0      = with_lamp(8'h00);
        t.byte_count = COUNT_BACKLIGHT;
        t.final_wait = WAIT_NONE;
        new_transfers.push_back(t);
      end
      default: ;
    endcase
    if (new_transfers.size() > 0) begin
      t = new_transfers.pop_back();
      t.last = 1'b1;
      new_transfers.push_back(t);
    end
    foreach (new_transfers[i]) pending_transfers.push_back(new_transfers[i]);
    return new_transfers.size();
  endfunction

  function int pending_count();
    return pending_transfers.size();
  endfunction

  task report(string what);
    if (errors < 50) $display("[%0t] MISMATCH: %s", $time, what);
    errors++;
  endtask

  task check_field(string name, logic [7:0] got_v, logic [7:0] want_v);
    if (got_v !== want_v)
      report($sformatf("%s got %h, expected %h", name, got_v, want_v));
  endtask

  task check_transfer(lcd_transfer_t got);
    lcd_transfer_t want;
    if (pending_transfers.size() == 0) begin
      report($sformatf("result %h with no transfer outstanding", got));
      return;
    end
    want = pending_transfers.pop_front();
    check_field("byte0", got.byte0, want.byte0);
    check_field("byte1", got.byte1, want.byte1);
    check_field("byte2", got.byte2, want.byte2);
    check_field("byte3", got.byte3, want.byte3);
    check_field("byte_count", got.byte_count, want.byte_count);
    check_field("final_wait", got.final_wait, want.final_wait);
    check_field("last", got.last, want.last);
  endtask
endclass

module char_lcd_text_to_expander_bytes_test;

  localparam int         WATCHDOG_LIMIT = 3000;
  localparam int         SETTLE_CYCLES  = 30;   // longest request is a padded newline
  localparam int         LONG_HOLD      = 300;
  localparam int         NUM_REGS       = CFG_RS_BIT + 1;
  localparam logic [2:0] CMD_FIRST_UNUSED = CMD_BACKLIGHT + 3'd1;
  localparam logic [2:0] CMD_LAST_UNUSED  = 3'd7;
  localparam logic [1:0] SETTING_ON     = 2'd1;
  localparam logic [1:0] SETTING_SPARE  = 2'd3;
  localparam logic [7:0] CHAR_TILDE     = 8'h7E;

  logic clk = 1'b0;
  logic rst = 1'b1;

  clcd_req_if req ();
  clcd_res_if res ();
  clcd_cfg_if cfg ();

  char_lcd_text_to_expander_bytes dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .res (res),
    .cfg (cfg)
  );

  expander_byte_checker sb = new();

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit long_hold_wanted = 1'b0;
  int idle_cycles = 0;

  lcd_transfer_t seen;
  assign seen = {res.byte0, res.byte1, res.byte2, res.byte3,
                 res.byte_count, res.final_wait, res.last};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Check every accepted result against the oldest owed transfer.
  always @(posedge clk) begin
    if (!rst && res.valid === 1'b1 && res.ready === 1'b1) sb.check_transfer(seen);
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (req.valid === 1'b1 && req.ready === 1'b1) ||
        (res.valid === 1'b1 && res.ready === 1'b1) ||
        (cfg.valid === 1'b1 && cfg.ready === 1'b1))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side: stall at random, or hold off for a long stretch on demand.
  initial begin
    int hold_left;
    hold_left = 0;
    res.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_hold_wanted) begin
        long_hold_wanted = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        res.ready <= 1'b0;
        hold_left--;
      end else begin
        res.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
      @(negedge clk);
    end
  end

  function automatic lcd_request_t make_request(logic [2:0] cmd, logic [7:0] ch,
                                                logic [7:0] col, logic [7:0] row,
                                                logic [1:0] setting);
    lcd_request_t r;
    r.cmd            = cmd;
    r.char_code      = ch;
    r.column_request = col;
    r.row_request    = row;
    r.setting        = setting;
    return r;
  endfunction

  // Mostly printable text with newlines and homes, some positioning and control,
  // and a little noise: unused commands and arbitrary character codes.
  function automatic lcd_request_t random_request();
    lcd_request_t r;
    int pick;
    int kind;
    r.cmd            = CMD_PUT_CHAR;
    r.char_code      = 8'($urandom);
    r.column_request = 8'($urandom);
    r.row_request    = 8'($urandom);
    r.setting        = 2'($urandom);
    pick = $urandom_range(99);
    if (pick < 55) begin
      kind = $urandom_range(99);
      if (kind < 12) r.char_code = CHAR_NEWLINE;
      else if (kind < 17) r.char_code = CHAR_HOME;
      else if (kind < 85) r.char_code = 8'($urandom_range(CHAR_TILDE, CHAR_SPACE));
    end else if (pick < 67) begin
      r.cmd = CMD_SET_POS;
      // keep half of them within or just past the wide panel so the clamp is hit from both sides
      if ($urandom_range(1)) begin
        r.column_request = 8'($urandom_range(COLS_WIDE));
        r.row_request    = 8'($urandom_range(ROWS_WIDE));
      end
    end else if (pick < 75) begin
      r.cmd = CMD_CURSOR;
    end else if (pick < 83) begin
      r.cmd = CMD_SCREEN;
    end else if (pick < 91) begin
      r.cmd = CMD_BACKLIGHT;
    end else begin
      r.cmd = 3'($urandom_range(CMD_LAST_UNUSED, CMD_FIRST_UNUSED));
    end
    return r;
  endfunction

  // Offer one request; entered and left at a falling edge, valid left high.
  task automatic offer(lcd_request_t r);
    if ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req.valid          <= 1'b1;
    req.cmd            <= r.cmd;
    req.char_code      <= r.char_code;
    req.column_request <= r.column_request;
    req.row_request    <= r.row_request;
    req.setting        <= r.setting;
    do @(posedge clk); while (req.ready !== 1'b1);
    void'(sb.note_request(r));
    @(negedge clk);
  endtask

  task automatic run_random(int count);
    repeat (count) offer(random_request());
  endtask

  // Drop valid, wait for every owed transfer, then let the block settle.
  task automatic drain();
    req.valid <= 1'b0;
    while (sb.pending_count() > 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write every register in turn, keeping valid high across the burst.
  task automatic apply_settings(logic wide, logic pads, logic [3:0] lamp,
                                logic [3:0] strobe, logic [3:0] select);
    logic [3:0] reg_values [NUM_REGS];
    reg_values[CFG_PANEL_KIND]    = {3'b000, wide};
    reg_values[CFG_NEWLINE_PADS]  = {3'b000, pads};
    reg_values[CFG_BACKLIGHT_BIT] = lamp;
    reg_values[CFG_ENABLE_BIT]    = strobe;
    reg_values[CFG_RS_BIT]        = select;
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg.valid <= 1'b1;
      cfg.index <= i[2:0];
      cfg.data  <= reg_values[i];
      do @(posedge clk); while (cfg.ready !== 1'b1);
      sb.write_register(i[2:0], reg_values[i]);
      @(negedge clk);
    end
    cfg.valid <= 1'b0;
  endtask

  initial begin
    req.valid          = 1'b0;
    req.cmd            = CMD_PUT_CHAR;
    req.char_code      = '0;
    req.column_request = '0;
    req.row_request    = '0;
    req.setting        = SETTING_OFF;
    cfg.valid          = 1'b0;
    cfg.index          = CFG_PANEL_KIND;
    cfg.data           = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed requests on the reset settings: narrow panel, no padding.
    send_idle_pct = 31;
    recv_idle_pct = 88;
    offer(make_request(CMD_BACKLIGHT, 8'h00, 8'h00, 8'h00, SETTING_ON));
    offer(make_request(CMD_PUT_CHAR, 8'h41, 8'hFF, 8'hFF, SETTING_SPARE));
    offer(make_request(CMD_PUT_CHAR, 8'hFF, 8'h00, 8'h00, SETTING_OFF));
    offer(make_request(CMD_PUT_CHAR, 8'h01, 8'h00, 8'h00, SETTING_OFF));
    offer(make_request(CMD_PUT_CHAR, 8'h80, 8'h00, 8'h00, SETTING_OFF));
    offer(make_request(CMD_CURSOR, 8'h00, 8'h00, 8'h00, SETTING_OFF));
    offer(make_request(CMD_CURSOR, 8'h00, 8'h00, 8'h00, SETTING_ON));
    offer(make_request(CMD_CURSOR, 8'h00, 8'h00, 8'h00, SETTING_BLINK));
    offer(make_request(CMD_CURSOR, 8'h00, 8'h00, 8'h00, SETTING_SPARE));
    offer(make_request(CMD_SCREEN, 8'h00, 8'h00, 8'h00, SETTING_OFF));
    offer(make_request(CMD_SCREEN, 8'h00, 8'h00, 8'h00, SETTING_ON));
    offer(make_request(CMD_SCREEN, 8'h00, 8'h00, 8'h00, SETTING_BLINK));
    offer(make_request(CMD_BACKLIGHT, 8'h00, 8'h00, 8'h00, SETTING_OFF));
    // clamp to the bottom right, fill the last cell, then run off the end
    offer(make_request(CMD_SET_POS, 8'h00, 8'hFF, 8'hFF, SETTING_OFF));
    offer(make_request(CMD_PUT_CHAR, 8'h78, 8'h00, 8'h00, SETTING_OFF));
    offer(make_request(CMD_PUT_CHAR, 8'h79, 8'h00, 8'h00, SETTING_OFF));
    // newline from the last row wraps home, the next one moves down
    offer(make_request(CMD_PUT_CHAR, CHAR_NEWLINE, 8'h00, 8'h00, SETTING_OFF));
    offer(make_request(CMD_PUT_CHAR, CHAR_NEWLINE, 8'h00, 8'h00, SETTING_OFF));
    offer(make_request(CMD_PUT_CHAR, CHAR_HOME, 8'h00, 8'h00, SETTING_OFF));
    offer(make_request(CMD_SET_POS, 8'h00, 8'h00, 8'h00, SETTING_OFF));
    offer(make_request(CMD_SET_POS, 8'h00, 8'h07, 8'h01, SETTING_OFF));
    offer(make_request(CMD_FIRST_UNUSED, 8'h41, 8'h00, 8'h00, SETTING_ON));
    offer(make_request(CMD_FIRST_UNUSED + 3'd1, 8'h41, 8'h00, 8'h00, SETTING_ON));
    offer(make_request(CMD_LAST_UNUSED, 8'h41, 8'h00, 8'h00, SETTING_ON));
    offer(make_request(CMD_BACKLIGHT, 8'h00, 8'h00, 8'h00, SETTING_SPARE));
    drain();

    // Wide panel with padding: a newline from column 0 owes the longest burst.
    apply_settings(1'b1, 1'b1, 4'h8, 4'h4, 4'h1);
    offer(make_request(CMD_PUT_CHAR, CHAR_HOME, 8'h00, 8'h00, SETTING_OFF));
    offer(make_request(CMD_PUT_CHAR, CHAR_NEWLINE, 8'h00, 8'h00, SETTING_OFF));
    offer(make_request(CMD_SET_POS, 8'h00, 8'h05, 8'h02, SETTING_OFF));
    run_random(55);
    // leave the cursor past the last column of the narrow panel, on row 3
    offer(make_request(CMD_SET_POS, 8'h00, 8'h13, 8'h03, SETTING_OFF));
    offer(make_request(CMD_PUT_CHAR, 8'h5A, 8'h00, 8'h00, SETTING_OFF));
    drain();

    // Narrow panel with padding and the stale wide position: the character is
    // dropped, and the newline gets no padding and goes home.
    apply_settings(1'b0, 1'b1, 4'hF, 4'h0, 4'hF);
    offer(make_request(CMD_PUT_CHAR, 8'h71, 8'h00, 8'h00, SETTING_OFF));
    offer(make_request(CMD_PUT_CHAR, CHAR_NEWLINE, 8'h00, 8'h00, SETTING_OFF));
    run_random(55);
    drain();

    // Swap the idle pattern and hold the result side off while requests queue up.
    send_idle_pct = 88;
    recv_idle_pct = 31;
    apply_settings(1'b1, 1'b0, 4'h0, 4'hF, 4'h0);
    long_hold_wanted = 1'b1;
    run_random(55);
    drain();

    // No idling at all, with the lamp, strobe and select lines on separate bits.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    apply_settings(1'b0, 1'b0, 4'h2, 4'h1, 4'h4);
    run_random(55);
    drain();

    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
